[rtl/core/lru_kv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_kv_pkg: shared types and constants for the LRU key/value cache
// Sizes, operation codes, item structs and the control/status bundles.
// ----------------------------------------------------------------------------
package lru_kv_pkg;

    localparam int ENTRIES    = 64;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int IDX_BITS   = $clog2(ENTRIES);
    localparam int OCC_BITS   = $clog2(ENTRIES + 1);

    localparam logic [1:0] FUNC_PROBE  = 2'd0;
    localparam logic [1:0] FUNC_GET    = 2'd1;
    localparam logic [1:0] FUNC_INSERT = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] key;
        logic [31:0] value;
    } lru_kv_in_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_value;
        logic        evicted;
        logic [31:0] evicted_key;
    } lru_kv_out_t;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic commit;
    } lru_kv_cmd_t;

    typedef struct packed {
        logic scan_last;
    } lru_kv_sts_t;

endpackage

[rtl/core/lru_kv_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_kv_ram: generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lru_kv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/lru_kv_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_kv_datapath: slot store and sequential slot scan
// Walks every slot once per item to match the key, find the oldest slot and
// the first empty slot, then updates the ages in a second sweep and commits.
// ----------------------------------------------------------------------------
module lru_kv_datapath
    import lru_kv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  lru_kv_cmd_t cmd,
    output lru_kv_sts_t sts,
    input  lru_kv_in_t  item_in,
    output lru_kv_out_t item_out
);

    // Scan phase: index advances; reads return in the following cycle.
    // Phase 0 = search, phase 1 = age update.
    logic [IDX_BITS-1:0] idx_reg, idx_next;
    logic                rd_ok_reg, rd_ok_next;
    logic [IDX_BITS-1:0] rd_idx_reg;
    logic                phase_reg, phase_next;

    lru_kv_in_t          item_reg;
    logic [ENTRIES-1:0]  valid_reg, valid_next;
    logic [OCC_BITS-1:0] occ_reg, occ_next;

    logic                found_reg, found_next;
    logic [IDX_BITS-1:0] found_idx_reg, found_idx_next;
    logic [IDX_BITS-1:0] found_age_reg, found_age_next;
    logic [VALUE_BITS-1:0] found_val_reg, found_val_next;
    logic                empty_reg, empty_next;
    logic [IDX_BITS-1:0] empty_idx_reg, empty_idx_next;
    logic [IDX_BITS-1:0] old_idx_reg, old_idx_next;
    logic [IDX_BITS-1:0] old_age_reg, old_age_next;
    logic [KEY_BITS-1:0] old_key_reg, old_key_next;
    logic                old_seen_reg, old_seen_next;

    logic [KEY_BITS-1:0]   key_rd;
    logic [VALUE_BITS-1:0] val_rd;
    logic [IDX_BITS-1:0]   age_rd;

    logic                  key_we, val_we, age_we;
    logic [IDX_BITS-1:0]   key_wa, age_wa;
    logic [IDX_BITS-1:0]   age_wd;
    logic [IDX_BITS-1:0]   tgt_idx;
    logic [OCC_BITS-1:0]   old_rank;
    logic                  do_touch;
    logic                  scan_done;

    lru_kv_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key (
        .aclk(aclk), .we(key_we), .waddr(key_wa), .wdata(item_reg.key[KEY_BITS-1:0]),
        .raddr(idx_reg), .rdata(key_rd)
    );
    lru_kv_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES)) u_val (
        .aclk(aclk), .we(val_we), .waddr(key_wa),
        .wdata(item_reg.value[VALUE_BITS-1:0]), .raddr(idx_reg), .rdata(val_rd)
    );
    lru_kv_ram #(.WIDTH(IDX_BITS), .DEPTH(ENTRIES)) u_age (
        .aclk(aclk), .we(age_we), .waddr(age_wa), .wdata(age_wd),
        .raddr(idx_reg), .rdata(age_rd)
    );

    assign scan_done = rd_ok_reg && (rd_idx_reg == IDX_BITS'(ENTRIES - 1));
    assign sts.scan_last = (idx_reg == IDX_BITS'(ENTRIES - 1));

    // Target slot and its old rank for the touch.
    always_comb begin
        do_touch = 1'b0;
        tgt_idx  = found_idx_reg;
        old_rank = OCC_BITS'(found_age_reg);
        if (item_reg.func == FUNC_GET) begin
            do_touch = found_reg;
        end else if (item_reg.func == FUNC_INSERT) begin
            do_touch = 1'b1;
            if (!found_reg) begin
                if (occ_reg != OCC_BITS'(ENTRIES)) begin
                    tgt_idx  = empty_idx_reg;
                    old_rank = occ_reg;
                end else begin
                    tgt_idx  = old_idx_reg;
                    old_rank = OCC_BITS'(old_age_reg);
                end
            end
        end
    end

    always_comb begin
        idx_next       = idx_reg;
        rd_ok_next     = 1'b0;
        phase_next     = phase_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        found_age_next = found_age_reg;
        found_val_next = found_val_reg;
        empty_next     = empty_reg;
        empty_idx_next = empty_idx_reg;
        old_idx_next   = old_idx_reg;
        old_age_next   = old_age_reg;
        old_key_next   = old_key_reg;
        old_seen_next  = old_seen_reg;
        valid_next     = valid_reg;
        occ_next       = occ_reg;
        key_we = 1'b0;
        val_we = 1'b0;
        age_we = 1'b0;
        key_wa = tgt_idx;
        age_wa = rd_idx_reg;
        age_wd = age_rd + IDX_BITS'(1);

        if (cmd.load) begin
            idx_next      = '0;
            phase_next    = 1'b0;
            found_next    = 1'b0;
            empty_next    = 1'b0;
            old_seen_next = 1'b0;
            old_idx_next  = '0;
        end
        if (cmd.scan_step) begin
            rd_ok_next = 1'b1;
            if (idx_reg != IDX_BITS'(ENTRIES - 1)) begin
                idx_next = idx_reg + IDX_BITS'(1);
            end
        end
        if (rd_ok_reg && !phase_reg) begin
            if (valid_reg[rd_idx_reg]) begin
                if (!found_reg && key_rd == item_reg.key[KEY_BITS-1:0]) begin
                    found_next     = 1'b1;
                    found_idx_next = rd_idx_reg;
                    found_age_next = age_rd;
                    found_val_next = val_rd;
                end
                if (!old_seen_reg || age_rd >= old_age_reg) begin
                    old_seen_next = 1'b1;
                    old_idx_next  = rd_idx_reg;
                    old_age_next  = age_rd;
                    old_key_next  = key_rd;
                end
            end else if (!empty_reg) begin
                empty_next     = 1'b1;
                empty_idx_next = rd_idx_reg;
            end
            if (scan_done) begin
                phase_next = 1'b1;
                idx_next   = '0;
            end
        end
        if (rd_ok_reg && phase_reg && do_touch) begin
            if (rd_idx_reg == tgt_idx) begin
                age_we = 1'b1;
                age_wd = '0;
            end else if (valid_reg[rd_idx_reg] && OCC_BITS'(age_rd) < old_rank) begin
                age_we = 1'b1;
            end
        end
        if (cmd.commit && do_touch) begin
            if (item_reg.func == FUNC_INSERT) begin
                val_we = 1'b1;
                key_we = !found_reg;
                if (!found_reg && occ_reg != OCC_BITS'(ENTRIES)) begin
                    valid_next[tgt_idx] = 1'b1;
                    occ_next = occ_reg + OCC_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            occ_reg   <= '0;
            rd_ok_reg <= 1'b0;
            phase_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            rd_ok_reg <= rd_ok_next;
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
        end
        rd_idx_reg    <= idx_reg;
        found_reg     <= found_next;
        found_idx_reg <= found_idx_next;
        found_age_reg <= found_age_next;
        found_val_reg <= found_val_next;
        empty_reg     <= empty_next;
        empty_idx_reg <= empty_idx_next;
        old_idx_reg   <= old_idx_next;
        old_age_reg   <= old_age_next;
        old_key_reg   <= old_key_next;
        old_seen_reg  <= old_seen_next;
        if (cmd.load) begin
            item_reg <= item_in;
        end
    end

    always_comb begin
        item_out = '0;
        if (item_reg.func == FUNC_PROBE || item_reg.func == FUNC_GET ||
            item_reg.func == FUNC_INSERT) begin
            item_out.hit = found_reg;
        end
        if (item_reg.func == FUNC_GET && found_reg) begin
            item_out.read_value = 32'(found_val_reg);
        end
        if (item_reg.func == FUNC_INSERT && !found_reg && !empty_reg) begin
            item_out.evicted     = 1'b1;
            item_out.evicted_key = 32'(old_key_reg);
        end
    end

`ifndef SYNTHESIS
    a_occ_range: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_BITS'(ENTRIES))
        else $error("occupancy above capacity");
    a_occ_match: assert property (@(posedge aclk) disable iff (!aresetn)
        OCC_BITS'($countones(valid_reg)) == occ_reg)
        else $error("occupancy differs from valid count");
    a_occ_step: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg != $past(occ_reg) |-> $past(cmd.commit))
        else $error("occupancy changed outside commit");
`endif

endmodule

[rtl/core/lru_kv_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_kv_ctrl: sequencer for the LRU key/value cache
// Accepts an item, runs search and age sweeps, commits and presents the item.
// ----------------------------------------------------------------------------
module lru_kv_ctrl
    import lru_kv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    output lru_kv_cmd_t cmd,
    input  lru_kv_sts_t sts
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_GAP    = 3'd2;
    localparam logic [2:0] ST_AGE    = 3'd3;
    localparam logic [2:0] ST_COMMIT = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       issue_reg, issue_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    always_comb begin
        state_next    = state_reg;
        issue_next    = issue_reg;
        cmd           = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    issue_next = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                cmd.scan_step = issue_reg;
                if (sts.scan_last) begin
                    issue_next = 1'b0;
                    state_next = ST_GAP;
                end else if (issue_reg) begin
                    issue_next = 1'b1;
                end
            end
            ST_GAP: begin
                issue_next = 1'b1;
                state_next = ST_AGE;
            end
            ST_AGE: begin
                cmd.scan_step = issue_reg;
                if (sts.scan_last) begin
                    issue_next = 1'b0;
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            issue_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            issue_reg <= issue_next;
        end
    end

`ifndef SYNTHESIS
    a_hs_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and output both open");
    a_commit_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid)
        else $error("commit not followed by result");
    a_load_search: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == ST_SEARCH)
        else $error("load not followed by search");
`endif

endmodule

[rtl/core/lru_key_value_cache.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key/value cache, LRU replacement
// Probe, get and insert on ENTRIES slots held in RAMs with per-slot ranks.
// ----------------------------------------------------------------------------
// Channel  Ports            Direction  Payload
// input    s_valid/s_ready  in         lru_kv_in_t  (func, key, value)
// result   m_valid/m_ready  out        lru_kv_out_t (hit, read_value, evicted,
//                                                    evicted_key)
// Each item runs one sweep over the slot RAM read port to search, one sweep
// to update the ages, then a commit, and then waits for the output.
// Reset clears valid marks and occupancy directly; no clearing pass.
// One item is in work at a time; a stalled result holds the block.
// ----------------------------------------------------------------------------
module lru_key_value_cache
    import lru_kv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  lru_kv_in_t  s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output lru_kv_out_t m_data
);

    lru_kv_cmd_t cmd;
    lru_kv_sts_t sts;

    lru_kv_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .cmd(cmd), .sts(sts)
    );

    lru_kv_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .item_in(s_data), .item_out(m_data)
    );

endmodule

[tb/sv/lru_key_value_cache_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb: self-checking bench for the LRU key/value cache
// A directed table, a fill, then random probe, get, insert and unused-code
// items are driven into the input channel. A behavioral LRU store predicts
// every result; each is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;
    import lru_kv_pkg::*;

    localparam int RANDOM_ITEMS = 1750;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct {
        lru_kv_in_t  item;
        logic        fixed;
        lru_kv_out_t result;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    lru_kv_in_t  s_data;
    logic        m_valid;
    logic        m_ready;
    lru_kv_out_t m_data;

    lru_kv_out_t pending_results[$];
    int          error_count;
    logic        quiet_phase;
    logic        hold_sink;

    logic        pv_valid[ENTRIES];
    logic [31:0] pv_key[ENTRIES];
    logic [31:0] pv_value[ENTRIES];
    int          pv_age[ENTRIES];
    int          pv_count;

    logic [31:0] key_pool[16];
    dir_row_t    dir_rows[$];

    lru_key_value_cache DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic promote_slot(input int s, input int old_rank);
        for (int i = 0; i < ENTRIES; i++) begin
            if (i != s && pv_valid[i] && pv_age[i] < old_rank) begin
                pv_age[i]++;
            end
        end
        pv_age[s] = 0;
    endtask

    function automatic int find_slot(input logic [31:0] key);
        for (int i = 0; i < ENTRIES; i++) begin
            if (pv_valid[i] && pv_key[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    task automatic predict_lookup(input lru_kv_in_t it, output lru_kv_out_t r);
        int f;
        int s;
        r = '0;
        f = find_slot(it.key);
        case (it.func)
            FUNC_PROBE: begin
                r.hit = (f >= 0);
            end
            FUNC_GET: begin
                if (f >= 0) begin
                    r.hit = 1'b1;
                    r.read_value = pv_value[f];
                    promote_slot(f, pv_age[f]);
                end
            end
            FUNC_INSERT: begin
                if (f >= 0) begin
                    r.hit = 1'b1;
                    pv_value[f] = it.value;
                    promote_slot(f, pv_age[f]);
                end else if (pv_count < ENTRIES) begin
                    s = 0;
                    while (pv_valid[s]) s++;
                    pv_valid[s] = 1'b1;
                    pv_key[s] = it.key;
                    pv_value[s] = it.value;
                    promote_slot(s, pv_count);
                    pv_count++;
                end else begin
                    s = 0;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (pv_valid[i] && pv_age[i] >= pv_age[s]) s = i;
                    end
                    r.evicted = 1'b1;
                    r.evicted_key = pv_key[s];
                    pv_key[s] = it.key;
                    pv_value[s] = it.value;
                    promote_slot(s, pv_age[s]);
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input lru_kv_in_t it, input logic fixed,
                             input lru_kv_out_t fixed_result);
        lru_kv_out_t r;
        @(negedge aclk);
        while (!quiet_phase && $urandom_range(99) < 9) @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_lookup(it, r);
        if (fixed && r != fixed_result) begin
            report_mismatch("directed row disagrees with prediction");
        end
        pending_results.push_back(r);
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    always @(negedge aclk) begin
        m_ready <= !hold_sink && (quiet_phase || $urandom_range(99) >= 9);
    end

    always @(posedge aclk) begin
        lru_kv_out_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no item outstanding");
            end else begin
                e = pending_results.pop_front();
                if (m_data.hit !== e.hit)
                    report_mismatch($sformatf("hit %0b exp %0b", m_data.hit, e.hit));
                if (m_data.read_value !== e.read_value)
                    report_mismatch($sformatf("read_value %h exp %h",
                                              m_data.read_value, e.read_value));
                if (m_data.evicted !== e.evicted)
                    report_mismatch($sformatf("evicted %0b exp %0b",
                                              m_data.evicted, e.evicted));
                if (m_data.evicted_key !== e.evicted_key)
                    report_mismatch($sformatf("evicted_key %h exp %h",
                                              m_data.evicted_key, e.evicted_key));
            end
        end
    end

    function automatic lru_kv_in_t mk(input logic [1:0] f, input logic [31:0] k,
                                      input logic [31:0] v);
        lru_kv_in_t it;
        it.func = f;
        it.key = k;
        it.value = v;
        return it;
    endfunction

    task automatic add_row(input lru_kv_in_t it, input logic fixed,
                           input logic h, input logic [31:0] rv);
        dir_row_t row;
        row.item = it;
        row.fixed = fixed;
        row.result = '0;
        row.result.hit = h;
        row.result.read_value = rv;
        dir_rows.push_back(row);
    endtask

    initial begin
        lru_kv_in_t it;
        int roll;
        error_count = 0;
        quiet_phase = 1'b0;
        hold_sink = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        pv_count = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            pv_valid[i] = 1'b0;
            pv_key[i] = '0;
            pv_value[i] = '0;
            pv_age[i] = 0;
        end
        for (int i = 0; i < 16; i++) key_pool[i] = $urandom;
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        add_row(mk(FUNC_PROBE, 32'h0, 32'h0), 1'b1, 1'b0, 32'h0);
        add_row(mk(FUNC_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1, 1'b0, 32'h0);
        add_row(mk(FUNC_UNUSED, 32'h1234_5678, 32'h9ABC_DEF0), 1'b1, 1'b0, 32'h0);
        add_row(mk(FUNC_INSERT, 32'h0, 32'hFFFF_FFFF), 1'b1, 1'b0, 32'h0);
        add_row(mk(FUNC_INSERT, 32'hFFFF_FFFF, 32'h0), 1'b1, 1'b0, 32'h0);
        add_row(mk(FUNC_PROBE, 32'h0, 32'h5555_5555), 1'b1, 1'b1, 32'h0);
        add_row(mk(FUNC_GET, 32'h0, 32'h0), 1'b1, 1'b1, 32'hFFFF_FFFF);
        add_row(mk(FUNC_GET, 32'hFFFF_FFFF, 32'h0), 1'b1, 1'b1, 32'h0);
        add_row(mk(FUNC_INSERT, 32'h0, 32'hA5A5_A5A5), 1'b1, 1'b1, 32'h0);
        add_row(mk(FUNC_GET, 32'h0, 32'h0), 1'b1, 1'b1, 32'hA5A5_A5A5);
        add_row(mk(FUNC_UNUSED, 32'h0, 32'h0), 1'b1, 1'b0, 32'h0);
        add_row(mk(FUNC_GET, 32'h1, 32'h0), 1'b1, 1'b0, 32'h0);
        foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].fixed,
                                        dir_rows[i].result);

        for (int i = 0; i < ENTRIES + 6; i++) begin
            send_item(mk(FUNC_INSERT, 32'h100 + i, $urandom), 1'b0, '0);
        end
        send_item(mk(FUNC_GET, 32'h106, 32'h0), 1'b0, '0);
        send_item(mk(FUNC_INSERT, 32'h200, $urandom), 1'b0, '0);

        while (pending_results.size() != 0) @(posedge aclk);
        @(negedge aclk);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet_phase = (n >= 600 && n < 900);
            if (n == 1000) begin
                while (pending_results.size() != 0) @(posedge aclk);
                @(negedge aclk);
            end
            if (n == 1200) begin
                hold_sink = 1'b1;
                repeat (300) @(negedge aclk);
                hold_sink = 1'b0;
            end
            roll = $urandom_range(99);
            it.func = (roll < 5) ? FUNC_UNUSED : (roll < 35) ? FUNC_PROBE :
                      (roll < 65) ? FUNC_GET : FUNC_INSERT;
            if ($urandom_range(99) < 40) it.key = key_pool[$urandom_range(15)];
            else if ($urandom_range(99) < 70) it.key = $urandom_range(95);
            else it.key = $urandom;
            it.value = $urandom;
            send_item(it, 1'b0, '0);
        end
        hold_sink = 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (2 * ENTRIES + 20) @(posedge aclk);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

[filelist.f]
rtl/core/lru_kv_pkg.sv
rtl/core/lru_kv_ram.sv
rtl/core/lru_kv_datapath.sv
rtl/core/lru_kv_ctrl.sv
rtl/core/lru_key_value_cache.sv
tb/sv/lru_key_value_cache_tb.sv
